[rtl/slmv_pkg.sv]
// ----------------------------------------------------------------------------
// slmv_pkg - shared types and constants for the line move sequencer
// Command and axis codes, coil pattern lookup.
// ----------------------------------------------------------------------------
package slmv_pkg;

  typedef logic [1:0] cmd_t;
  typedef logic [1:0] axis_t;
  typedef logic [1:0] phase_t;
  typedef logic [3:0] coils_t;

  localparam cmd_t CMD_START = 2'd0;
  localparam cmd_t CMD_TICK  = 2'd1;
  localparam cmd_t CMD_ZSTEP = 2'd2;

  localparam axis_t AXIS_NONE = 2'd0;
  localparam axis_t AXIS_X    = 2'd1;
  localparam axis_t AXIS_Y    = 2'd2;
  localparam axis_t AXIS_Z    = 2'd3;

  // phase to one-hot coil drive, bit3 is coil one
  function automatic coils_t coil_pattern(input phase_t ph);
    coils_t c;
    case (ph)
      2'd0:    c = 4'b1000;
      2'd1:    c = 4'b0010;
      2'd2:    c = 4'b0100;
      2'd3:    c = 4'b0001;
      default: c = 4'b1000;
    endcase
    return c;
  endfunction

endpackage

[rtl/slmv_if.sv]
// ----------------------------------------------------------------------------
// slmv_if - command and result channels of the line move sequencer
// Valid/ready channels; an item moves when valid and ready are both high.
// ----------------------------------------------------------------------------
interface slmv_cmd_if
  import slmv_pkg::*;
#(
  parameter int MOVE_BITS = 16
) ();
  logic                 valid;
  logic                 ready;
  cmd_t                 cmd;
  logic [MOVE_BITS-1:0] move_x;
  logic [MOVE_BITS-1:0] move_y;
  logic                 z_dir;

  modport source (output valid, cmd, move_x, move_y, z_dir, input ready);
  modport sink   (input valid, cmd, move_x, move_y, z_dir, output ready);
endinterface

interface slmv_res_if
  import slmv_pkg::*;
();
  logic   valid;
  logic   ready;
  coils_t x_coils;
  coils_t y_coils;
  coils_t z_coils;
  axis_t  stepped_axis;
  logic   busy_res;
  logic   move_done;

  modport source (output valid, x_coils, y_coils, z_coils, stepped_axis, busy_res, move_done,
                  input ready);
  modport sink   (input valid, x_coils, y_coils, z_coils, stepped_axis, busy_res, move_done,
                  output ready);
endinterface

[rtl/slmv_div.sv]
// ----------------------------------------------------------------------------
// slmv_div - iterative unsigned divider
// Restoring division, one quotient bit per cycle; done is raised once the last bit is in.
// ----------------------------------------------------------------------------
module slmv_div
  import slmv_pkg::*;
#(
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         done,
  output logic [W-1:0] quotient
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem;
  logic [W-1:0]  quo;
  logic [W-1:0]  dvs;
  logic [CW-1:0] cnt;
  logic [W:0]    shifted;
  logic [W:0]    diff;
  logic          ge;

  assign shifted  = {rem, quo[W-1]};
  assign diff     = shifted - {1'b0, dvs};
  assign ge       = shifted >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= '0;
        quo <= dividend;
        dvs <= divisor;
        cnt <= CW'(W);
      end else if (cnt != '0) begin
        rem  <= ge ? diff[W-1:0] : shifted[W-1:0];
        quo  <= {quo[W-2:0], ge};
        cnt  <= cnt - 1'b1;
        done <= (cnt == CW'(1));
      end
    end
  end

endmodule

[rtl/stepper_line_move_sequencer.sv]
// ----------------------------------------------------------------------------
// stepper_line_move_sequencer - two-axis full-step line move sequencer
// Start, tick and Z step commands drive X, Y and Z coil phases.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries commands: start a move (signed X/Y counts), tick (make the
//   next step of the move) or a single Z step. out_ch returns one result item
//   per command: coil patterns of all axes, the axis stepped, busy and done.
//   A start, Z step, spare command or a tick inside a burst passes through the
//   EXEC and APPLY states before its result is registered. A tick that opens
//   a burst first runs the restoring divider in the DIV state, between EXEC
//   and APPLY. in_ch takes no new command until the item has been applied.
//   One command is in work at a time; in_ch is ready whenever the sequencer
//   is idle, also while a result waits in out_ch.
//   A stalled receiver holds the result register; the sequencer then waits
//   in its final state with the next result until the slot frees.
//   Reset clears the phases (coils show 1000), the remaining counts and the
//   burst state; no result is pending after reset.
// ----------------------------------------------------------------------------
module stepper_line_move_sequencer
  import slmv_pkg::*;
#(
  parameter int MOVE_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  slmv_cmd_if.sink   in_ch,
  slmv_res_if.source out_ch
);

  localparam int MB = MOVE_BITS;

  typedef enum logic [1:0] {ST_IDLE, ST_EXEC, ST_DIV, ST_APPLY} state_t;

  state_t               state;
  cmd_t                 item_cmd;
  logic                 item_zdir;
  logic [MB-1:0]        item_mx;
  logic [MB-1:0]        item_my;

  phase_t               phase_x, phase_y, phase_z;
  logic signed [MB:0]   remain_x, remain_y;
  logic [MB-1:0]        burst_left;
  logic                 x_is_major, minor_pending;

  phase_t               phase_x_next, phase_y_next, phase_z_next;
  logic signed [MB:0]   remain_x_next, remain_y_next;
  logic [MB-1:0]        burst_left_next;
  logic                 x_is_major_next, minor_pending_next;
  axis_t                axis_next;
  logic                 busy_next, done_next;

  logic signed [MB:0]   maj, mnr, sx, sy;
  logic [MB:0]          maj_abs, mnr_abs, sx_abs, sy_abs;
  logic                 need_div, do_x, do_y, step_maj, step_min, out_free;
  logic                 div_done;
  logic [MB-1:0]        div_q;

  assign in_ch.ready = (state == ST_IDLE);
  assign out_free    = !out_ch.valid || out_ch.ready;

  assign maj     = x_is_major ? remain_x : remain_y;
  assign mnr     = x_is_major ? remain_y : remain_x;
  assign maj_abs = maj[MB] ? -maj : maj;
  assign mnr_abs = mnr[MB] ? -mnr : mnr;
  assign sx      = $signed({item_mx[MB-1], item_mx});
  assign sy      = $signed({item_my[MB-1], item_my});
  assign sx_abs  = sx[MB] ? -sx : sx;
  assign sy_abs  = sy[MB] ? -sy : sy;

  assign need_div = (item_cmd == CMD_TICK) && (mnr != '0) && !minor_pending
                    && (burst_left == '0);

  slmv_div #(.W(MB)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (state == ST_EXEC && need_div),
    .dividend (maj_abs[MB-1:0]),
    .divisor  (mnr_abs[MB-1:0]),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    phase_x_next       = phase_x;
    phase_y_next       = phase_y;
    phase_z_next       = phase_z;
    remain_x_next      = remain_x;
    remain_y_next      = remain_y;
    burst_left_next    = burst_left;
    x_is_major_next    = x_is_major;
    minor_pending_next = minor_pending;
    axis_next          = AXIS_NONE;
    step_maj           = 1'b0;
    step_min           = 1'b0;
    case (item_cmd)
      CMD_START: begin
        remain_x_next      = sx;
        remain_y_next      = sy;
        x_is_major_next    = sx_abs > sy_abs;
        burst_left_next    = '0;
        minor_pending_next = 1'b0;
      end
      CMD_TICK: begin
        if (remain_x == '0 && remain_y == '0) begin
          burst_left_next    = '0;
          minor_pending_next = 1'b0;
        end else if (burst_left != '0 && maj != '0) begin
          burst_left_next = burst_left - 1'b1;
          step_maj        = 1'b1;
        end else begin
          burst_left_next    = '0;
          minor_pending_next = 1'b0;
          if (minor_pending && mnr != '0) begin
            step_min = 1'b1;
          end else if (maj != '0) begin
            step_maj = 1'b1;
          end else begin
            step_min = 1'b1;
          end
        end
      end
      CMD_ZSTEP: begin
        phase_z_next = phase_z + (item_zdir ? 2'd3 : 2'd1);
        axis_next    = AXIS_Z;
      end
      default: begin
      end
    endcase
    do_x = (step_maj && x_is_major) || (step_min && !x_is_major);
    do_y = (step_maj && !x_is_major) || (step_min && x_is_major);
    if (do_x) begin
      if (remain_x > 0) begin
        phase_x_next  = phase_x + 2'd1;
        remain_x_next = remain_x - 1'b1;
      end else begin
        phase_x_next  = phase_x + 2'd3;
        remain_x_next = remain_x + 1'b1;
      end
      axis_next = AXIS_X;
    end
    if (do_y) begin
      if (remain_y > 0) begin
        phase_y_next  = phase_y + 2'd3;
        remain_y_next = remain_y - 1'b1;
      end else begin
        phase_y_next  = phase_y + 2'd1;
        remain_y_next = remain_y + 1'b1;
      end
      axis_next = AXIS_Y;
    end
    busy_next = (remain_x_next != '0) || (remain_y_next != '0);
    done_next = (item_cmd == CMD_TICK) && (do_x || do_y) && !busy_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase_x       <= '0;
      phase_y       <= '0;
      phase_z       <= '0;
      remain_x      <= '0;
      remain_y      <= '0;
      burst_left    <= '0;
      x_is_major    <= 1'b0;
      minor_pending <= 1'b0;
      out_ch.valid  <= 1'b0;
    end else begin
      if (state == ST_APPLY && out_free) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_ch.valid) begin
            item_cmd  <= in_ch.cmd;
            item_zdir <= in_ch.z_dir;
            item_mx   <= in_ch.move_x;
            item_my   <= in_ch.move_y;
            state     <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          state <= need_div ? ST_DIV : ST_APPLY;
        end
        ST_DIV: begin
          if (div_done) begin
            burst_left    <= div_q;
            minor_pending <= 1'b1;
            state         <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          if (out_free) begin
            phase_x             <= phase_x_next;
            phase_y             <= phase_y_next;
            phase_z             <= phase_z_next;
            remain_x            <= remain_x_next;
            remain_y            <= remain_y_next;
            burst_left          <= burst_left_next;
            x_is_major          <= x_is_major_next;
            minor_pending       <= minor_pending_next;
            out_ch.x_coils      <= coil_pattern(phase_x_next);
            out_ch.y_coils      <= coil_pattern(phase_y_next);
            out_ch.z_coils      <= coil_pattern(phase_z_next);
            out_ch.stepped_axis <= axis_next;
            out_ch.busy_res     <= busy_next;
            out_ch.move_done    <= done_next;
            state               <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench - line move sequencer testbench
// Drives start, tick and Z step commands through the command channel and
// checks every result item against a cycle-free model of the step sequence.
// Directed corner cases first, then random moves, noise and handshake stalls.
// ----------------------------------------------------------------------------
module testbench;
  import slmv_pkg::*;

  localparam int          MOVE_BITS   = 16;
  localparam cmd_t        CMD_SPARE   = 2'd3;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 40;

  typedef logic [MOVE_BITS-1:0] move_t;

  typedef struct packed {
    coils_t x_coils;
    coils_t y_coils;
    coils_t z_coils;
    axis_t  stepped_axis;
    logic   busy_res;
    logic   move_done;
  } result_t;

  class line_move_scoreboard;
    phase_t      ph_x, ph_y, ph_z;
    int          rem_x, rem_y;
    int unsigned burst_cnt;
    bit          x_major;
    bit          minor_due;
    result_t     expected_results[$];
    int unsigned fail_count;
    int unsigned mismatch_count;

    function new();
      ph_x = '0;
      ph_y = '0;
      ph_z = '0;
      rem_x = 0;
      rem_y = 0;
      burst_cnt = 0;
      x_major = 1'b0;
      minor_due = 1'b0;
      fail_count = 0;
      mismatch_count = 0;
    endfunction

    function int unsigned magnitude(int v);
      return (v < 0) ? -v : v;
    endfunction

    function coils_t coil_drive(phase_t p);
      case (p)
        2'd0:    return 4'b1000;
        2'd1:    return 4'b0010;
        2'd2:    return 4'b0100;
        default: return 4'b0001;
      endcase
    endfunction

    function axis_t step_axis(bit on_x);
      if (on_x) begin
        if (rem_x > 0) begin
          ph_x = ph_x + 2'd1;
          rem_x--;
        end else begin
          ph_x = ph_x - 2'd1;
          rem_x++;
        end
        return AXIS_X;
      end
      // positive Y runs the phase downwards
      if (rem_y > 0) begin
        ph_y = ph_y - 2'd1;
        rem_y--;
      end else begin
        ph_y = ph_y + 2'd1;
        rem_y++;
      end
      return AXIS_Y;
    endfunction

    function axis_t next_line_step();
      int maj, mnr;
      if (rem_x == 0 && rem_y == 0) begin
        burst_cnt = 0;
        minor_due = 1'b0;
        return AXIS_NONE;
      end
      maj = x_major ? rem_x : rem_y;
      mnr = x_major ? rem_y : rem_x;
      if (mnr != 0 && !minor_due && burst_cnt == 0) begin
        burst_cnt = magnitude(maj) / magnitude(mnr);
        minor_due = 1'b1;
      end
      if (burst_cnt > 0 && maj != 0) begin
        burst_cnt--;
        return step_axis(x_major);
      end
      burst_cnt = 0;
      if (minor_due && mnr != 0) begin
        minor_due = 1'b0;
        return step_axis(!x_major);
      end
      minor_due = 1'b0;
      if (maj != 0) return step_axis(x_major);
      return step_axis(!x_major);
    endfunction

    function void note_command(cmd_t c, move_t mx, move_t my, logic zd);
      result_t r;
      axis_t   ax;
      bit      busy;
      ax = AXIS_NONE;
      case (c)
        CMD_START: begin
          rem_x = $signed(mx);
          rem_y = $signed(my);
          x_major = magnitude(rem_x) > magnitude(rem_y);
          burst_cnt = 0;
          minor_due = 1'b0;
        end
        CMD_TICK: ax = next_line_step();
        CMD_ZSTEP: begin
          ph_z = zd ? ph_z - 2'd1 : ph_z + 2'd1;
          ax = AXIS_Z;
        end
        default: ;
      endcase
      busy = (rem_x != 0) || (rem_y != 0);
      r.x_coils = coil_drive(ph_x);
      r.y_coils = coil_drive(ph_y);
      r.z_coils = coil_drive(ph_z);
      r.stepped_axis = ax;
      r.busy_res = busy;
      r.move_done = (c == CMD_TICK) && (ax == AXIS_X || ax == AXIS_Y) && !busy;
      expected_results.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (mismatch_count < 10)
          $display("%0t: result item with none expected: %p", $realtime, got);
        mismatch_count++;
        return;
      end
      want = expected_results.pop_front();
      if (got.x_coils !== want.x_coils || got.y_coils !== want.y_coils ||
          got.z_coils !== want.z_coils || got.stepped_axis !== want.stepped_axis ||
          got.busy_res !== want.busy_res || got.move_done !== want.move_done) begin
        fail_count++;
        if (mismatch_count < 10)
          $display("%0t: mismatch x %b/%b y %b/%b z %b/%b axis %0d/%0d busy %b/%b done %b/%b",
                   $realtime, want.x_coils, got.x_coils, want.y_coils, got.y_coils,
                   want.z_coils, got.z_coils, want.stepped_axis, got.stepped_axis,
                   want.busy_res, got.busy_res, want.move_done, got.move_done);
        mismatch_count++;
      end
    endfunction

    function int pending();
      return expected_results.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  slmv_cmd_if #(.MOVE_BITS(MOVE_BITS)) in_ch ();
  slmv_res_if out_ch ();

  stepper_line_move_sequencer #(
    .MOVE_BITS(MOVE_BITS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  line_move_scoreboard sb = new();

  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;
  bit          hold_req   = 1'b0;
  int unsigned items_sent = 0;

  always #10 clk = ~clk;

  task automatic send_cmd(input cmd_t c, input move_t mx, input move_t my, input logic zd);
    if (tx_idle_on && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.cmd    <= c;
    in_ch.move_x <= mx;
    in_ch.move_y <= my;
    in_ch.z_dir  <= zd;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    sb.note_command(c, mx, my, zd);
    items_sent++;
  endtask

  task automatic send_tick();
    send_cmd(CMD_TICK, move_t'($urandom), move_t'($urandom), 1'($urandom));
  endtask

  task automatic send_start(input int mx, input int my);
    send_cmd(CMD_START, mx[MOVE_BITS-1:0], my[MOVE_BITS-1:0], 1'($urandom));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic int rand_count(input int lim);
    int v;
    v = $urandom_range(0, 2 * lim);
    return v - lim;
  endfunction

  // start a move, then mostly ticks with the odd Z step, spare command or early abort
  task automatic random_move_sequence();
    int lim, mx, my, n, i;
    lim = 0;
    case ($urandom_range(0, 9))
      0, 1, 2:    lim = 3;
      3, 4, 5, 6: lim = 12;
      7:          lim = 40;
      default:    lim = 0;
    endcase
    if (lim == 0) begin
      mx = $signed(move_t'($urandom));
      my = ($urandom_range(0, 1) == 0) ? $signed(move_t'($urandom)) : rand_count(2);
      if ($urandom_range(0, 1) == 0) begin
        i = mx;
        mx = my;
        my = i;
      end
      n = $urandom_range(1, 24);
    end else begin
      mx = rand_count(lim);
      my = rand_count(lim);
      n = (mx < 0 ? -mx : mx) + (my < 0 ? -my : my) + $urandom_range(0, 2);
    end
    send_start(mx, my);
    i = 0;
    while (i < n) begin
      case ($urandom_range(0, 49))
        0, 1, 2, 3: send_cmd(CMD_ZSTEP, move_t'($urandom), move_t'($urandom), 1'($urandom));
        4:          send_cmd(CMD_SPARE, move_t'($urandom), move_t'($urandom), 1'($urandom));
        5:          i = n;
        default: begin
          send_tick();
          i++;
        end
      endcase
    end
  endtask

  task automatic noise_burst();
    repeat ($urandom_range(1, 5)) send_cmd(cmd_t'($urandom_range(0, 3)), move_t'($urandom),
                                           move_t'($urandom), 1'($urandom));
  endtask

  task automatic random_phase(input int unsigned until_items);
    while (items_sent < until_items) begin
      if ($urandom_range(0, 7) == 0) noise_burst();
      else random_move_sequence();
    end
  endtask

  initial begin : result_side
    int unsigned stall_left;
    result_t     got;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_ch.valid && out_ch.ready) begin
        got.x_coils      = out_ch.x_coils;
        got.y_coils      = out_ch.y_coils;
        got.z_coils      = out_ch.z_coils;
        got.stepped_axis = out_ch.stepped_axis;
        got.busy_res     = out_ch.busy_res;
        got.move_done    = out_ch.move_done;
        sb.check_result(got);
      end
      if (rst) begin
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        out_ch.ready <= 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 15);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    in_ch.valid  <= 1'b0;
    in_ch.cmd    <= CMD_TICK;
    in_ch.move_x <= '0;
    in_ch.move_y <= '0;
    in_ch.z_dir  <= 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle tick and spare command show reset coils
    send_tick();
    send_cmd(CMD_SPARE, 16'hffff, 16'hffff, 1'b1);
    send_cmd(CMD_ZSTEP, '0, '0, 1'b0);
    send_cmd(CMD_ZSTEP, '0, '0, 1'b1);
    send_cmd(CMD_ZSTEP, '0, '0, 1'b0);
    send_start(0, 0);
    send_tick();
    send_start(2, 0);
    repeat (3) send_tick();
    send_start(0, -2);
    send_tick();
    send_cmd(CMD_ZSTEP, '0, '0, 1'b1);
    send_tick();
    // equal magnitudes, Y major
    send_start(1, -1);
    repeat (2) send_tick();
    send_start(-5, 2);
    send_tick();
    // restart while busy, field extremes
    send_start(32767, -32768);
    send_tick();
    send_start(-32768, 32767);
    send_tick();
    send_start(0, 0);

    random_phase(330);

    // receiver holds off while commands keep coming
    tx_idle_on = 1'b0;
    hold_req = 1'b1;
    send_start(20, -7);
    repeat (12) send_tick();
    drain_results();

    tx_idle_on = 1'b1;
    rx_idle_on = 1'b0;
    random_phase(550);
    drain_results();

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b1;
    random_phase(700);

    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    random_phase(850);

    drain_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[stepper_line_move_sequencer.f]
rtl/slmv_pkg.sv
rtl/slmv_if.sv
rtl/slmv_div.sv
rtl/stepper_line_move_sequencer.sv
dv/testbench.sv
